>>> src/bfba_pkg.sv
// Shared types and codes for the best-fit block allocator.
`timescale 1ns / 1ps
`default_nettype none
package bfba_pkg;

	localparam int unsigned SIZE_W  = 16;
	localparam int unsigned INDEX_W = 4;
	localparam int unsigned FREE_W  = 20;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_ALLOC = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_ALLOC  = 2'd0,
		ST_NOFIT  = 2'd1,
		ST_LOADED = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DRAIN,
		FSM_FINISH
	} fsm_t;

	typedef struct packed {
		op_t               op;
		logic [SIZE_W-1:0] size;
		logic              last_request;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [INDEX_W-1:0] block_index;
		logic [SIZE_W-1:0]  fragment;
		logic [FREE_W-1:0]  free_total;
		logic               run_end;
	} rsp_t;

endpackage
`default_nettype wire

>>> src/best_fit_block_allocator_top.sv
// Best-fit block allocator: block table, scan sequencer and shared comparator.
//
// channel | dir | handshake        | payload
// req     | in  | req_valid/stall  | req_t: op, size, last_request
// rsp     | out | rsp_valid/stall  | rsp_t: status, block_index, fragment, free_total, run_end
//
// A load goes from the idle step straight to the finish step; an allocation walks
// every table entry with one comparator through the single read port of the size
// memory, one entry a cycle, then passes a drain and a finish step. The result is
// registered into the output register in the finish step.
// Reset clears the free bits, the load count and the free total at once; no sweep.
// A result waits in the output register while the next beat is accepted; a
// finished step holds in its last state until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none
module best_fit_block_allocator_top
	import bfba_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS = 16,
	parameter int unsigned SIZE_BITS  = 16
) (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire       rsp_stall,
	output rsp_t      rsp
);

	localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

	fsm_t state_q, state_d;

	logic [SIZE_BITS-1:0] mem [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0] free_q;
	logic [CW-1:0]         cnt_q;
	logic [FREE_W-1:0]     free_sum_q;

	op_t                  op_q;
	logic [SIZE_BITS-1:0] req_size_q;
	logic                 last_q;

	logic [IW-1:0]        ptr_q;
	logic [SIZE_BITS-1:0] rd_s1;
	logic [IW-1:0]        ptr_s1;
	logic                 vld_s1;

	logic                 found_q;
	logic [IW-1:0]        best_q;
	logic [SIZE_BITS-1:0] best_frag_q;
	logic [SIZE_BITS-1:0] best_size_q;

	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic                 req_fire;
	logic                 scan_en;
	logic                 out_free;
	logic                 fin_fire;
	logic                 full;
	logic                 load_we;
	logic [31:0]          size_ext;
	logic [SIZE_BITS-1:0] size_in;
	logic [SIZE_BITS:0]   diff;
	logic                 better;
	logic [31:0]          req_ext;
	logic [31:0]          best_size_ext;
	logic [31:0]          frag_ext;
	logic [31:0]          best_ext;
	logic [31:0]          cnt_ext;
	rsp_t                 res;

	assign size_ext = {16'b0, req.size};
	assign size_in  = size_ext[SIZE_BITS-1:0];
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign full     = (cnt_q == CW'(MAX_BLOCKS));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (req_valid) begin
					state_d = (req.op == OP_ALLOC) ? FSM_SCAN : FSM_FINISH;
				end
			end
			FSM_SCAN: begin
				if (ptr_q == IW'(MAX_BLOCKS - 1)) begin
					state_d = FSM_DRAIN;
				end
			end
			FSM_DRAIN:  state_d = FSM_FINISH;
			FSM_FINISH: begin
				if (out_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req_stall = 1'b1;
		scan_en   = 1'b0;
		fin_fire  = 1'b0;
		unique case (state_q)
			FSM_IDLE:   req_stall = 1'b0;
			FSM_SCAN:   scan_en   = 1'b1;
			FSM_DRAIN:  ;
			FSM_FINISH: fin_fire  = out_free;
			default:    ;
		endcase
	end

	assign req_fire = req_valid && !req_stall;
	assign load_we  = fin_fire && (op_q == OP_LOAD) && !full;

	// shared comparator: fits and leaves a smaller fragment
	assign diff   = {1'b0, rd_s1} - {1'b0, req_size_q};
	assign better = vld_s1 && !diff[SIZE_BITS]
	                && (!found_q || (diff[SIZE_BITS-1:0] < best_frag_q));

	// result of the step
	always_comb begin
		req_ext       = 32'(req_size_q);
		best_size_ext = 32'(best_size_q);
		frag_ext      = 32'(best_frag_q);
		best_ext      = 32'(best_q);
		cnt_ext       = 32'(cnt_q);
		res.run_end     = last_q;
		res.block_index = '0;
		res.fragment    = '0;
		res.free_total  = free_sum_q;
		if (op_q == OP_LOAD) begin
			if (full) begin
				res.status = ST_FULL;
			end else begin
				res.status      = ST_LOADED;
				res.block_index = cnt_ext[INDEX_W-1:0];
				res.free_total  = free_sum_q + req_ext[FREE_W-1:0];
			end
		end else if (found_q) begin
			res.status      = ST_ALLOC;
			res.block_index = best_ext[INDEX_W-1:0];
			res.fragment    = frag_ext[SIZE_W-1:0];
			res.free_total  = free_sum_q - best_size_ext[FREE_W-1:0];
		end else begin
			res.status = ST_NOFIT;
		end
	end

	// size table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[cnt_q[IW-1:0]] <= req_size_q;
		end
		rd_s1 <= mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			free_q      <= '0;
			cnt_q       <= '0;
			free_sum_q  <= '0;
			ptr_q       <= '0;
			vld_s1      <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= scan_en && free_q[ptr_q];
			if (req_fire) begin
				ptr_q   <= '0;
				found_q <= 1'b0;
			end else if (scan_en) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (better) begin
				found_q <= 1'b1;
			end
			if (fin_fire) begin
				rsp_valid_q <= 1'b1;
				free_sum_q  <= res.free_total;
				if (load_we) begin
					free_q[cnt_q[IW-1:0]] <= 1'b1;
					cnt_q                 <= cnt_q + 1'b1;
				end
				if ((op_q == OP_ALLOC) && found_q) begin
					free_q[best_q] <= 1'b0;
				end
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		ptr_s1 <= ptr_q;
		if (req_fire) begin
			op_q       <= req.op;
			req_size_q <= size_in;
			last_q     <= req.last_request;
		end
		if (better) begin
			best_q      <= ptr_s1;
			best_frag_q <= diff[SIZE_BITS-1:0];
			best_size_q <= rd_s1;
		end
		if (fin_fire) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_BLOCKS))
		else $error("load count beyond table depth");

	a_best_is_free: assert property (@(posedge clk) disable iff (!arst_n)
		found_q && ((state_q == FSM_SCAN) || (state_q == FSM_DRAIN)) |-> free_q[best_q])
		else $error("best candidate is not a free block");

	a_commit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fin_fire && (op_q == OP_ALLOC) && found_q |=> !free_q[$past(best_q)])
		else $error("allocated block still marked free");

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == FSM_FINISH))
		else $error("result raised outside the finish step");

	a_no_scan_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == FSM_SCAN) || (state_q == FSM_DRAIN))
		else $error("compare beat outside a scan");

endmodule
`default_nettype wire

>>> verif/tb_best_fit_block_allocator_top.sv
// Self-checking testbench for the best-fit block allocator: table fill, allocation and no-fit.
`timescale 1ns / 1ps
module tb_best_fit_block_allocator_top;
	import bfba_pkg::*;

	localparam int unsigned TABLE_DEPTH = 16;
	localparam int unsigned SIZE_BITS   = 16;
	localparam int unsigned RANDOM_ITEMS = 800;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned REPORT_LIMIT = 10;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_beat  = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_beat;

	best_fit_block_allocator_top #(
		.MAX_BLOCKS(TABLE_DEPTH),
		.SIZE_BITS (SIZE_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req_beat),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp_beat)
	);

	// Predictor state: block table, free flags, fill count, running free total.
	logic [SIZE_W-1:0] tbl_size [TABLE_DEPTH];
	bit                tbl_free [TABLE_DEPTH];
	int unsigned       n_loaded = 0;
	logic [20:0]       free_acc = '0;

	req_t pending_req_q [$];
	rsp_t expected_rsp_q [$];

	bit          req_taken = 1'b0;
	int unsigned req_gap_left = 0;
	int unsigned req_mode = 1;
	int unsigned rsp_stall_left = 0;
	int unsigned rsp_mode = 1;

	int unsigned fail_cnt = 0;
	int unsigned beats_checked = 0;
	int unsigned load_cnt = 0;
	int unsigned full_cnt = 0;
	int unsigned alloc_cnt = 0;
	int unsigned placed_cnt = 0;
	int unsigned nofit_cnt = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic req_t make_req(op_t op, int unsigned size, bit last);
		req_t r;
		r.op           = op;
		r.size         = size[SIZE_W-1:0];
		r.last_request = last;
		return r;
	endfunction

	// Mode 0 never idles; mode 1 idles briefly now and then; mode 2 idles more and longer.
	function automatic int unsigned pick_gap(int unsigned mode);
		int unsigned roll;
		roll = $urandom_range(0, 15);
		if (mode == 0)
			return 0;
		if (mode == 1) begin
			if (roll < 10)
				return 0;
			if (roll < 15)
				return $urandom_range(1, 3);
			return $urandom_range(8, 30);
		end
		if (roll < 4)
			return 0;
		if (roll < 13)
			return $urandom_range(1, 5);
		return $urandom_range(20, 60);
	endfunction

	// Apply one request to the predictor state and return the result it should give.
	function automatic rsp_t best_fit_step(req_t r);
		rsp_t              o;
		bit                hit;
		logic [SIZE_W-1:0] best_frag;
		logic [SIZE_W-1:0] frag;
		int unsigned       best_idx;
		int unsigned       j;
		o         = '0;
		o.run_end = r.last_request;
		if (r.op == OP_LOAD) begin
			if (n_loaded < TABLE_DEPTH) begin
				tbl_size[n_loaded] = r.size;
				tbl_free[n_loaded] = 1'b1;
				free_acc           = free_acc + r.size;
				o.block_index      = n_loaded[INDEX_W-1:0];
				n_loaded++;
				o.status = ST_LOADED;
			end else begin
				o.status = ST_FULL;
			end
		end else begin
			hit       = 1'b0;
			best_frag = '0;
			best_idx  = 0;
			for (j = 0; j < n_loaded; j++) begin
				if (tbl_free[j] && tbl_size[j] >= r.size) begin
					frag = tbl_size[j] - r.size;
					// strict compare keeps the lowest index on a tie
					if (!hit || frag < best_frag) begin
						hit       = 1'b1;
						best_frag = frag;
						best_idx  = j;
					end
				end
			end
			if (hit) begin
				tbl_free[best_idx] = 1'b0;
				free_acc           = free_acc - tbl_size[best_idx];
				o.block_index      = best_idx[INDEX_W-1:0];
				o.fragment         = best_frag;
				o.status           = ST_ALLOC;
			end else begin
				o.status = ST_NOFIT;
			end
		end
		o.free_total = free_acc[FREE_W-1:0];
		return o;
	endfunction

	// Driver: present the next beat once the current one is taken, with random gaps.
	always @(negedge clk) begin
		logic drive_valid;
		req_t drive_item;
		if (arst_n) begin
			if (!req_valid || req_taken) begin
				drive_valid = 1'b0;
				drive_item  = req_beat;
				if (req_gap_left > 0) begin
					req_gap_left--;
				end else if (pending_req_q.size() > 0) begin
					drive_valid  = 1'b1;
					drive_item   = pending_req_q.pop_front();
					req_gap_left = pick_gap(req_mode);
					if ($urandom_range(0, 63) == 0)
						req_mode = $urandom_range(0, 2);
				end
				req_valid <= drive_valid;
				req_beat  <= drive_item;
			end

			if (rsp_stall_left > 0) begin
				rsp_stall <= 1'b1;
				rsp_stall_left--;
			end else begin
				rsp_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0)
					rsp_stall_left = pick_gap(rsp_mode);
			end
			if ($urandom_range(0, 99) == 0)
				rsp_mode = $urandom_range(0, 2);
		end
	end

	// Monitor: predict on every accepted request, check every accepted result.
	always @(posedge clk) begin
		rsp_t exp_rsp;
		bit   bad;
		req_taken <= req_valid && !req_stall;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				exp_rsp = best_fit_step(req_beat);
				expected_rsp_q.push_back(exp_rsp);
				case (exp_rsp.status)
					ST_LOADED: load_cnt++;
					ST_FULL: begin
						load_cnt++;
						full_cnt++;
					end
					ST_ALLOC: begin
						alloc_cnt++;
						placed_cnt++;
					end
					default: begin
						alloc_cnt++;
						nofit_cnt++;
					end
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				beats_checked++;
				if (expected_rsp_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= REPORT_LIMIT)
						$display("[%0t] unexpected result beat: status=%0d idx=%0d frag=%0d free=%0d end=%0b",
							$time, rsp_beat.status, rsp_beat.block_index, rsp_beat.fragment,
							rsp_beat.free_total, rsp_beat.run_end);
				end else begin
					exp_rsp = expected_rsp_q.pop_front();
					bad = (rsp_beat.status !== exp_rsp.status)
						|| (rsp_beat.block_index !== exp_rsp.block_index)
						|| (rsp_beat.fragment !== exp_rsp.fragment)
						|| (rsp_beat.free_total !== exp_rsp.free_total)
						|| (rsp_beat.run_end !== exp_rsp.run_end);
					if (bad) begin
						fail_cnt++;
						if (fail_cnt <= REPORT_LIMIT) begin
							$display("[%0t] beat %0d expected: status=%0d idx=%0d frag=%0d free=%0d end=%0b",
								$time, beats_checked, exp_rsp.status, exp_rsp.block_index,
								exp_rsp.fragment, exp_rsp.free_total, exp_rsp.run_end);
							$display("[%0t] beat %0d actual:   status=%0d idx=%0d frag=%0d free=%0d end=%0b",
								$time, beats_checked, rsp_beat.status, rsp_beat.block_index,
								rsp_beat.fragment, rsp_beat.free_total, rsp_beat.run_end);
						end
					end
				end
			end
		end
	end

	initial begin
		int unsigned k;
		int unsigned roll;
		int unsigned sz;
		bit          lr;

		// Empty table: both ends of the size range find nothing.
		pending_req_q.push_back(make_req(OP_ALLOC, 0, 1'b0));
		pending_req_q.push_back(make_req(OP_ALLOC, 16'hFFFF, 1'b1));
		pending_req_q.push_back(make_req(OP_LOAD, 16'hFFFF, 1'b0));
		pending_req_q.push_back(make_req(OP_LOAD, 0, 1'b0));
		pending_req_q.push_back(make_req(OP_LOAD, 100, 1'b1));
		pending_req_q.push_back(make_req(OP_LOAD, 100, 1'b0));
		pending_req_q.push_back(make_req(OP_LOAD, 300, 1'b0));
		// Zero size takes the empty block; equal fits resolve to the lower index, then skip it.
		pending_req_q.push_back(make_req(OP_ALLOC, 0, 1'b0));
		pending_req_q.push_back(make_req(OP_ALLOC, 50, 1'b0));
		pending_req_q.push_back(make_req(OP_ALLOC, 50, 1'b1));
		pending_req_q.push_back(make_req(OP_ALLOC, 16'hFFFF, 1'b0));
		pending_req_q.push_back(make_req(OP_ALLOC, 301, 1'b0));
		// Fill the rest of the table with a spread of sizes.
		pending_req_q.push_back(make_req(OP_LOAD, 16'hFFFF, 1'b0));
		pending_req_q.push_back(make_req(OP_LOAD, 16'hFFFF, 1'b1));
		for (k = 0; k < 9; k++) begin
			if (k < 3)
				sz = $urandom_range(0, 255);
			else if (k < 6)
				sz = $urandom_range(0, 4095);
			else
				sz = $urandom_range(0, 65535);
			pending_req_q.push_back(make_req(OP_LOAD, sz, $urandom_range(0, 1)));
		end
		pending_req_q.push_back(make_req(OP_LOAD, 16'h1234, 1'b1));
		pending_req_q.push_back(make_req(OP_ALLOC, 300, 1'b1));

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			roll = $urandom_range(0, 9);
			if (roll < 4)
				sz = $urandom_range(0, 255);
			else if (roll < 7)
				sz = $urandom_range(0, 4095);
			else
				sz = $urandom_range(0, 65535);
			lr = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 99) < 85)
				pending_req_q.push_back(make_req(OP_ALLOC, sz, lr));
			else
				pending_req_q.push_back(make_req(OP_LOAD, $urandom_range(0, 65535), lr));
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_req_q.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d loads (%0d refused on a full table) and %0d allocation requests (%0d placed, %0d no fit)",
			load_cnt, full_cnt, alloc_cnt, placed_cnt, nofit_cnt);
		$display("%0d result beats checked, %0d failures", beats_checked, fail_cnt);
		if (fail_cnt == 0 && expected_rsp_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout with %0d results outstanding", expected_rsp_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> filelist.f
src/bfba_pkg.sv
src/best_fit_block_allocator_top.sv
verif/tb_best_fit_block_allocator_top.sv
